FILE: hdl/tsq_pkg.sv
// shared types and codes for the timestamp ordered request queue
// no dependencies; imported by tsq_cell, timestamp_ordered_request_queue and its testbench
package tsq_pkg;

    localparam int TIME_W  = 15;
    localparam int ID_W    = 4;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY_POP = 2'd2,
        STAT_RSVD      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2,
        CELL_RSVD   = 2'd3
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t          op;
        logic [TIME_W-1:0] new_time;
        logic [ID_W-1:0]   new_id;
    } cell_ctrl_t;

endpackage

FILE: hdl/tsq_cell.sv
// one slot of the sorted chain: holds a (timestamp, id) pair
// depends on tsq_pkg
module tsq_cell (
    input  logic                      clk,
    input  tsq_pkg::cell_ctrl_t       ctrl,
    input  logic                      occ,
    input  logic                      prev_before,
    input  logic [tsq_pkg::TIME_W-1:0] prev_time,
    input  logic [tsq_pkg::ID_W-1:0]   prev_id,
    input  logic [tsq_pkg::TIME_W-1:0] next_time,
    input  logic [tsq_pkg::ID_W-1:0]   next_id,
    output logic [tsq_pkg::TIME_W-1:0] time_q,
    output logic [tsq_pkg::ID_W-1:0]   id_q,
    output logic                      ahead
);
    import tsq_pkg::*;

    logic [TIME_W-1:0] time_reg, time_next;
    logic [ID_W-1:0]   id_reg, id_next;

    // new request sorts ahead of this slot, or the slot is free
    assign ahead = !occ
                || (ctrl.new_time < time_reg)
                || ((ctrl.new_time == time_reg) && (ctrl.new_id < id_reg));

    always_comb
    begin
        time_next = time_reg;
        id_next   = id_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (prev_before)
                begin
                    // shift right, make room upstream
                    time_next = prev_time;
                    id_next   = prev_id;
                end
                else if (ahead)
                begin
                    time_next = ctrl.new_time;
                    id_next   = ctrl.new_id;
                end
            end
            CELL_POP:
            begin
                time_next = next_time;
                id_next   = next_id;
            end
            default:
            begin
                time_next = time_reg;
                id_next   = id_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign time_q = time_reg;
    assign id_q   = id_reg;

endmodule

FILE: hdl/timestamp_ordered_request_queue.sv
// top level of the timestamp ordered request queue
// depends on tsq_pkg and tsq_cell
//
// Queue of up to QUEUE_DEPTH requests kept sorted by timestamp and then by
// requester id, lowest first; a request equal to one already queued goes
// behind it. Each input beat carries one operation (insert, remove head,
// clear; the fourth mode code does nothing) and produces exactly one output
// beat with the head entry, the count, an empty flag and a status. The
// storage is a row of identical cells: on insert every cell compares the
// new request with its own entry in parallel and the cells behind the
// insertion point shift one place back; on remove every cell loads its
// downstream neighbor. Either way every cell updates on the same clock edge,
// so a new beat can be accepted every cycle while in_stall is low;
// the output register holds the result until it is taken, and in_stall is
// raised only while that result is waiting under out_stall. Head fields
// read zero when the queue is empty. Insert on a full queue and remove on
// an empty queue leave the queue as it was and report a status code.
// count is reported modulo 32 for depths above 31. No clearing pass is
// needed after reset: occupancy comes from the count register alone.
module timestamp_ordered_request_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tsq_pkg::MODE_W-1:0]  mode,
    input  logic [tsq_pkg::TIME_W-1:0]  req_stamp,
    input  logic [tsq_pkg::ID_W-1:0]    req_id,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [tsq_pkg::TIME_W-1:0]  head_time,
    output logic [tsq_pkg::ID_W-1:0]    head_id,
    output logic [tsq_pkg::COUNT_W-1:0] count,
    output logic                       is_empty,
    output logic [tsq_pkg::STAT_W-1:0]  status
);
    import tsq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // occupancy and result register
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    status_t          status_reg, status_next;

    logic       accept;
    mode_t      mode_in;
    cell_ctrl_t ctrl;

    // chain wiring
    logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
    logic [ID_W-1:0]   cell_id   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_before;
    logic [QUEUE_DEPTH-1:0] cell_occ;

    // a new beat is taken unless a finished result is stuck at the output
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign mode_in  = mode_t'(mode);

    // decode the operation; refused operations leave the chain untouched
    always_comb
    begin
        ctrl.op       = CELL_HOLD;
        ctrl.new_time = req_stamp;
        ctrl.new_id   = req_id;
        count_next    = count_reg;
        status_next   = STAT_OK;
        if (accept)
        begin
            unique case (mode_in)
                MODE_INSERT:
                begin
                    if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        status_next = STAT_FULL;
                    else
                    begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (count_reg == '0)
                        status_next = STAT_EMPTY_POP;
                    else
                    begin
                        ctrl.op    = CELL_POP;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_CLEAR:
                    count_next = '0;
                default:
                    count_next = count_reg;
            endcase
        end
    end

    // the chain of slots, head at index zero
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        logic              up_before;
        logic [TIME_W-1:0] up_time;
        logic [ID_W-1:0]   up_id;
        logic [TIME_W-1:0] dn_time;
        logic [ID_W-1:0]   dn_id;

        assign cell_occ[k] = count_reg > CNT_W'(k);

        if (k == 0)
        begin : g_first
            assign up_before = 1'b0;
            assign up_time   = cell_time[k];
            assign up_id     = cell_id[k];
        end
        else
        begin : g_mid
            assign up_before = cell_before[k-1];
            assign up_time   = cell_time[k-1];
            assign up_id     = cell_id[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            // tail slot becomes free on a pop, its content is don't care
            assign dn_time = cell_time[k];
            assign dn_id   = cell_id[k];
        end
        else
        begin : g_inner
            assign dn_time = cell_time[k+1];
            assign dn_id   = cell_id[k+1];
        end

        tsq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occ         (cell_occ[k]),
            .prev_before (up_before),
            .prev_time   (up_time),
            .prev_id     (up_id),
            .next_time   (dn_time),
            .next_id     (dn_id),
            .time_q      (cell_time[k]),
            .id_q        (cell_id[k]),
            .ahead       (cell_before[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                status_reg    <= status_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result fields come straight from state, which only moves on an accepted beat
    assign out_valid = out_valid_reg;
    assign is_empty  = (count_reg == '0);
    assign head_time = is_empty ? '0 : cell_time[0];
    assign head_id   = is_empty ? '0 : cell_id[0];
    assign count     = COUNT_W'(count_reg);
    assign status    = status_reg;

endmodule

FILE: verif/timestamp_ordered_request_queue_tb.sv
// self-checking testbench for the timestamp ordered request queue
// depends on tsq_pkg and timestamp_ordered_request_queue; drives beats,
// predicts every result beat in place and compares field by field
module timestamp_ordered_request_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 80;
    localparam int CHUNKS      = 25;
    localparam int CHUNK_BEATS = 50;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_LIMIT  = 10;

    // one request beat as the sender sees it
    typedef struct packed {
        mode_t             op;
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   who;
    } request_t;

    // one result beat: queue head and occupancy after the operation
    typedef struct packed {
        logic [TIME_W-1:0]  head_time;
        logic [ID_W-1:0]    head_id;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        status_t            status;
    } head_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request channel, all known from time zero
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [MODE_W-1:0]  mode = MODE_NOP;
    logic [TIME_W-1:0]  req_stamp = '0;
    logic [ID_W-1:0]    req_id = '0;

    // result channel
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [TIME_W-1:0]  head_time;
    logic [ID_W-1:0]    head_id;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic [STAT_W-1:0]  status;

    // beats waiting to be offered, and result beats still owed by the block
    request_t     requests_to_send[$];
    head_report_t head_reports_due[$];

    // sorted image of the queue, kept in step with accepted beats
    logic [TIME_W-1:0] sorted_time[DEPTH];
    logic [ID_W-1:0]   sorted_id[DEPTH];
    int                sorted_count = 0;

    // knobs set by the sequence at falling edges, read by driver and monitor
    bit no_idle = 1'b0;
    bit hold_go = 1'b0;

    int mismatches = 0;
    int cycles = 0;

    timestamp_ordered_request_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .req_stamp (req_stamp),
        .req_id    (req_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head_time (head_time),
        .head_id   (head_id),
        .count     (count),
        .is_empty  (is_empty),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one accepted request to the sorted image and report the head
    function automatic head_report_t apply_request(request_t r);
        head_report_t rep;
        int pos;
        int j;
        bit found;
        rep.status = STAT_OK;
        case (r.op)
            MODE_INSERT:
            begin
                if (sorted_count >= DEPTH)
                begin
                    rep.status = STAT_FULL;
                end
                else
                begin
                    // first slot holding a later stamp, or same stamp and higher id;
                    // an identical request lands behind the one already queued
                    pos = sorted_count;
                    found = 1'b0;
                    for (j = 0; j < sorted_count; j++)
                    begin
                        if (!found && (r.stamp < sorted_time[j] ||
                            (r.stamp == sorted_time[j] && r.who < sorted_id[j])))
                        begin
                            pos = j;
                            found = 1'b1;
                        end
                    end
                    for (j = sorted_count; j > pos; j--)
                    begin
                        sorted_time[j] = sorted_time[j-1];
                        sorted_id[j] = sorted_id[j-1];
                    end
                    sorted_time[pos] = r.stamp;
                    sorted_id[pos] = r.who;
                    sorted_count++;
                end
            end
            MODE_REMOVE:
            begin
                if (sorted_count == 0)
                begin
                    rep.status = STAT_EMPTY_POP;
                end
                else
                begin
                    for (j = 0; j + 1 < sorted_count; j++)
                    begin
                        sorted_time[j] = sorted_time[j+1];
                        sorted_id[j] = sorted_id[j+1];
                    end
                    sorted_count--;
                end
            end
            MODE_CLEAR:
            begin
                sorted_count = 0;
            end
            default:
            begin
                // spare mode code: queue untouched
            end
        endcase
        // head reads zero on an empty queue
        if (sorted_count > 0)
        begin
            rep.head_time = sorted_time[0];
            rep.head_id = sorted_id[0];
            rep.is_empty = 1'b0;
        end
        else
        begin
            rep.head_time = '0;
            rep.head_id = '0;
            rep.is_empty = 1'b1;
        end
        rep.count = sorted_count[COUNT_W-1:0];
        return rep;
    endfunction

    function automatic request_t make_request(mode_t op, int stamp, int who);
        request_t r;
        r.op = op;
        r.stamp = stamp[TIME_W-1:0];
        r.who = who[ID_W-1:0];
        return r;
    endfunction

    // random beat; insert_pct sets how hard the mix pushes toward full
    function automatic request_t random_request(int insert_pct);
        request_t r;
        int pick;
        int shape;
        pick = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        if (pick < 2)
            r.op = MODE_CLEAR;
        else if (pick < 4)
            r.op = MODE_NOP;
        else if (pick < 4 + insert_pct * 96 / 100)
            r.op = MODE_INSERT;
        else
            r.op = MODE_REMOVE;
        // stamps bunch at the ends and in a narrow band so ties on stamp are common
        case (shape)
            0:       r.stamp = '0;
            1:       r.stamp = '1;
            2, 3, 4: r.stamp = TIME_W'($urandom_range(0, 7));
            5:       r.stamp = TIME_W'($urandom_range(32760, 32767));
            default: r.stamp = TIME_W'($urandom_range(0, 32767));
        endcase
        // fields are random on every mode, ignored ones included
        r.who = ID_W'($urandom_range(0, 15));
        return r;
    endfunction

    // driver: a beat stays on the bus until taken; a new one goes up only
    // once the bus is free, and each output gets one assignment per edge
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_NOP;
            req_stamp <= '0;
            req_id <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                head_reports_due.push_back(apply_request(
                    make_request(mode_t'(mode), int'(req_stamp), int'(req_id))));
            if (!in_valid || !in_stall)
            begin
                if (requests_to_send.size() > 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = requests_to_send.pop_front();
                    in_valid <= 1'b1;
                    mode <= nxt.op;
                    req_stamp <= nxt.stamp;
                    req_id <= nxt.who;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes result beats, checks them against the oldest
    // prediction and drives out_stall, including the one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        head_report_t want;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (head_reports_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"unexpected beat: head %0d/%0d count %0d",
                                  " empty %0d status %0d"},
                                 head_time, head_id, count, is_empty, status);
                end
                else
                begin
                    want = head_reports_due.pop_front();
                    if (head_time !== want.head_time || head_id !== want.head_id ||
                        count !== want.count || is_empty !== want.is_empty ||
                        status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display({"beat differs: want %0d/%0d n%0d e%0d s%0d,",
                                      " got %0d/%0d n%0d e%0d s%0d"},
                                     want.head_time, want.head_id, want.count,
                                     want.is_empty, want.status,
                                     head_time, head_id, count, is_empty, status);
                    end
                end
            end
            // long hold-off: the output register stays full and the input backs up
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timestamp_ordered_request_queue: mismatch");
            $finish;
        end
    end

    // wait until nothing is queued, on the bus, or owed by the block
    task automatic drain_results();
        while (requests_to_send.size() > 0 || in_valid || head_reports_due.size() > 0)
            @(negedge clk);
    endtask

    // sequence: reset, directed corner cases, a full pause, then random chunks
    initial
    begin
        int c;
        int k;
        int insert_pct;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-queue ops, spare mode, extremes, ties, duplicates
        requests_to_send.push_back(make_request(MODE_REMOVE, 123, 7));   // pop on empty
        requests_to_send.push_back(make_request(MODE_CLEAR, 0, 0));      // clear when empty
        requests_to_send.push_back(make_request(MODE_NOP, 32767, 15));   // spare mode
        requests_to_send.push_back(make_request(MODE_INSERT, 32767, 15));
        requests_to_send.push_back(make_request(MODE_INSERT, 0, 0));
        requests_to_send.push_back(make_request(MODE_INSERT, 100, 5));
        requests_to_send.push_back(make_request(MODE_INSERT, 100, 2));   // tie, lower id first
        requests_to_send.push_back(make_request(MODE_INSERT, 100, 5));   // duplicate goes behind
        requests_to_send.push_back(make_request(MODE_REMOVE, 32767, 15));
        requests_to_send.push_back(make_request(MODE_INSERT, 0, 15));
        // fill to the top with falling stamps so each lands mid-queue
        for (k = 0; k < 11; k++)
            requests_to_send.push_back(make_request(MODE_INSERT, 20000 - k * 1500, 15 - k));
        requests_to_send.push_back(make_request(MODE_INSERT, 50, 1));    // refused, full
        requests_to_send.push_back(make_request(MODE_NOP, 0, 0));
        requests_to_send.push_back(make_request(MODE_REMOVE, 0, 0));
        requests_to_send.push_back(make_request(MODE_CLEAR, 32767, 15)); // clear when loaded
        requests_to_send.push_back(make_request(MODE_REMOVE, 0, 0));

        // sender pause: nothing more goes out until every result is back
        drain_results();

        // random chunks; the insert share sweeps so the queue swings full and empty
        for (c = 0; c < CHUNKS; c++)
        begin
            case (c % 6)
                0:       insert_pct = 85;
                1:       insert_pct = 55;
                2:       insert_pct = 25;
                3:       insert_pct = 50;
                4:       insert_pct = 70;
                default: insert_pct = 15;
            endcase
            no_idle = (c == 4 || c == 5 || c == 12);
            if (c == 12)
                hold_go = 1'b1;
            for (k = 0; k < CHUNK_BEATS; k++)
                requests_to_send.push_back(random_request(insert_pct));
            while (requests_to_send.size() > 0)
                @(negedge clk);
        end
        no_idle = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && head_reports_due.size() == 0)
            $display("timestamp_ordered_request_queue: match");
        else
            $display("timestamp_ordered_request_queue: mismatch");
        $finish;
    end

endmodule
